/* hw/rtl/wlsq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wlsq_pkg
// Shared types, constants and tables of the weighted plane fit core: state
// encoding, moment indexes, the term program of the normal equations and
// the rounding saturation helpers.
// ----------------------------------------------------------------------------
package wlsq_pkg;

   localparam int MOM_DEPTH      = 10;
   localparam int MOM_WIDTH      = 64;
   localparam int MAX_SAMPLES    = 32768;
   localparam int CNT_WIDTH      = $clog2(MAX_SAMPLES + 1);
   localparam int COEF_FRAC_BITS = 16;
   localparam int C_EXTRA_SHIFT  = 8;

   // wide datapath for determinants, numerators and the residual
   localparam int WIDE      = 256;
   localparam int DIV_CNT_W = $clog2(WIDE);

   // shared multiplier: 33 x 17 signed
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 17;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int MUL_STEPS = (WIDE / 32) * (MOM_WIDTH / 16);
   localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

   localparam logic [3:0] SMP_LAST  = 4'd9;
   localparam logic [2:0] MODEL_MAX = 3'd4;
   localparam logic [2:0] MODEL_RST = 3'd4;

   // moment indexes
   localparam logic [3:0] M_W  = 4'd0;
   localparam logic [3:0] M_X  = 4'd1;
   localparam logic [3:0] M_Y  = 4'd2;
   localparam logic [3:0] M_Z  = 4'd3;
   localparam logic [3:0] M_XX = 4'd4;
   localparam logic [3:0] M_XY = 4'd5;
   localparam logic [3:0] M_XZ = 4'd6;
   localparam logic [3:0] M_YY = 4'd7;
   localparam logic [3:0] M_YZ = 4'd8;
   localparam logic [3:0] M_ZZ = 4'd9;

   // first factor may also be a wide result
   localparam logic [3:0] S_DET = 4'd10;
   localparam logic [3:0] S_NA  = 4'd11;
   localparam logic [3:0] S_NB  = 4'd12;
   localparam logic [3:0] S_NC  = 4'd13;

   localparam int          ROM_W   = 6;
   localparam logic [5:0]  E_START = 6'd39;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_EST = 2'd1,
      OP_CLR = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SMP,
      ST_TERM_LOAD,
      ST_MUL_SETUP,
      ST_MUL_RUN,
      ST_MUL_FIX,
      ST_TERM_ACC,
      ST_DIV_SETUP,
      ST_DIV_PREP,
      ST_DIV_RUN,
      ST_DIV_FIX,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      DST_DET,
      DST_NA,
      DST_NB,
      DST_NC,
      DST_E
   } dst_type;

   typedef enum logic [1:0] {
      DIV_A,
      DIV_B,
      DIV_C,
      DIV_R
   } div_type;

   typedef struct packed {
      dst_type    dst;
      logic       neg;
      logic       dbl;
      logic [1:0] nf;
      logic [3:0] f1;
      logic [3:0] f2;
      logic [3:0] f3;
      logic       last;
   } term_type;

   function automatic term_type mk(input dst_type dst, input logic neg, input logic dbl,
                                   input logic [1:0] nf, input logic [3:0] f1,
                                   input logic [3:0] f2, input logic [3:0] f3,
                                   input logic last);
      term_type t;
      t.dst  = dst;
      t.neg  = neg;
      t.dbl  = dbl;
      t.nf   = nf;
      t.f1   = f1;
      t.f2   = f2;
      t.f3   = f3;
      t.last = last;
      return t;
   endfunction

   function automatic logic [ROM_W-1:0] model_start(input logic [2:0] m);
      logic [ROM_W-1:0] r;
      case (m)
         3'd0:    r = 6'd0;
         3'd1:    r = 6'd2;
         3'd2:    r = 6'd4;
         3'd3:    r = 6'd10;
         default: r = 6'd16;
      endcase
      return r;
   endfunction

   // Cramer's rule and residual terms, one signed product term per entry
   function automatic term_type term_rom(input logic [ROM_W-1:0] idx);
      term_type t;
      unique case (idx)
         6'd0:  t = mk(DST_DET, 1'b0, 1'b0, 2'd1, M_W,  M_W,  M_W,  1'b0);
         6'd1:  t = mk(DST_NC,  1'b0, 1'b0, 2'd1, M_Z,  M_W,  M_W,  1'b1);
         6'd2:  t = mk(DST_DET, 1'b0, 1'b0, 2'd1, M_XX, M_W,  M_W,  1'b0);
         6'd3:  t = mk(DST_NA,  1'b0, 1'b0, 2'd1, M_XZ, M_W,  M_W,  1'b1);
         6'd4:  t = mk(DST_DET, 1'b0, 1'b0, 2'd2, M_W,  M_XX, M_W,  1'b0);
         6'd5:  t = mk(DST_DET, 1'b1, 1'b0, 2'd2, M_X,  M_X,  M_W,  1'b0);
         6'd6:  t = mk(DST_NA,  1'b0, 1'b0, 2'd2, M_W,  M_XZ, M_W,  1'b0);
         6'd7:  t = mk(DST_NA,  1'b1, 1'b0, 2'd2, M_X,  M_Z,  M_W,  1'b0);
         6'd8:  t = mk(DST_NC,  1'b0, 1'b0, 2'd2, M_Z,  M_XX, M_W,  1'b0);
         6'd9:  t = mk(DST_NC,  1'b1, 1'b0, 2'd2, M_X,  M_XZ, M_W,  1'b1);
         6'd10: t = mk(DST_DET, 1'b0, 1'b0, 2'd2, M_XX, M_YY, M_W,  1'b0);
         6'd11: t = mk(DST_DET, 1'b1, 1'b0, 2'd2, M_XY, M_XY, M_W,  1'b0);
         6'd12: t = mk(DST_NA,  1'b0, 1'b0, 2'd2, M_YY, M_XZ, M_W,  1'b0);
         6'd13: t = mk(DST_NA,  1'b1, 1'b0, 2'd2, M_XY, M_YZ, M_W,  1'b0);
         6'd14: t = mk(DST_NB,  1'b0, 1'b0, 2'd2, M_XX, M_YZ, M_W,  1'b0);
         6'd15: t = mk(DST_NB,  1'b1, 1'b0, 2'd2, M_XY, M_XZ, M_W,  1'b1);
         6'd16: t = mk(DST_DET, 1'b0, 1'b0, 2'd3, M_YY, M_XX, M_W,  1'b0);
         6'd17: t = mk(DST_DET, 1'b1, 1'b0, 2'd3, M_YY, M_X,  M_X,  1'b0);
         6'd18: t = mk(DST_DET, 1'b1, 1'b0, 2'd3, M_XX, M_Y,  M_Y,  1'b0);
         6'd19: t = mk(DST_DET, 1'b1, 1'b0, 2'd3, M_XY, M_XY, M_W,  1'b0);
         6'd20: t = mk(DST_DET, 1'b0, 1'b1, 2'd3, M_X,  M_XY, M_Y,  1'b0);
         6'd21: t = mk(DST_NA,  1'b0, 1'b0, 2'd3, M_YY, M_XZ, M_W,  1'b0);
         6'd22: t = mk(DST_NA,  1'b1, 1'b0, 2'd3, M_YY, M_X,  M_Z,  1'b0);
         6'd23: t = mk(DST_NA,  1'b1, 1'b0, 2'd3, M_XZ, M_Y,  M_Y,  1'b0);
         6'd24: t = mk(DST_NA,  1'b0, 1'b0, 2'd3, M_X,  M_Y,  M_YZ, 1'b0);
         6'd25: t = mk(DST_NA,  1'b0, 1'b0, 2'd3, M_Y,  M_XY, M_Z,  1'b0);
         6'd26: t = mk(DST_NA,  1'b1, 1'b0, 2'd3, M_XY, M_YZ, M_W,  1'b0);
         6'd27: t = mk(DST_NB,  1'b0, 1'b0, 2'd3, M_YZ, M_XX, M_W,  1'b0);
         6'd28: t = mk(DST_NB,  1'b1, 1'b0, 2'd3, M_YZ, M_X,  M_X,  1'b0);
         6'd29: t = mk(DST_NB,  1'b1, 1'b0, 2'd3, M_XY, M_XZ, M_W,  1'b0);
         6'd30: t = mk(DST_NB,  1'b0, 1'b0, 2'd3, M_XY, M_X,  M_Z,  1'b0);
         6'd31: t = mk(DST_NB,  1'b1, 1'b0, 2'd3, M_Y,  M_XX, M_Z,  1'b0);
         6'd32: t = mk(DST_NB,  1'b0, 1'b0, 2'd3, M_Y,  M_X,  M_XZ, 1'b0);
         6'd33: t = mk(DST_NC,  1'b0, 1'b0, 2'd3, M_YY, M_XX, M_Z,  1'b0);
         6'd34: t = mk(DST_NC,  1'b0, 1'b0, 2'd3, M_Y,  M_XY, M_XZ, 1'b0);
         6'd35: t = mk(DST_NC,  1'b1, 1'b0, 2'd3, M_XX, M_Y,  M_YZ, 1'b0);
         6'd36: t = mk(DST_NC,  1'b1, 1'b0, 2'd3, M_YY, M_X,  M_XZ, 1'b0);
         6'd37: t = mk(DST_NC,  1'b1, 1'b0, 2'd3, M_XY, M_XY, M_Z,  1'b0);
         6'd38: t = mk(DST_NC,  1'b0, 1'b0, 2'd3, M_X,  M_XY, M_YZ, 1'b1);
         6'd39: t = mk(DST_E,   1'b0, 1'b0, 2'd2, S_DET, M_ZZ, M_W, 1'b0);
         6'd40: t = mk(DST_E,   1'b1, 1'b0, 2'd2, S_NA,  M_XZ, M_W, 1'b0);
         6'd41: t = mk(DST_E,   1'b1, 1'b0, 2'd2, S_NB,  M_YZ, M_W, 1'b0);
         6'd42: t = mk(DST_E,   1'b1, 1'b0, 2'd2, S_NC,  M_Z,  M_W, 1'b1);
         default: t = mk(DST_E, 1'b0, 1'b0, 2'd1, M_W,  M_W,  M_W,  1'b1);
      endcase
      return t;
   endfunction

   // product of sample step k goes to this moment
   function automatic logic [3:0] smp_dst(input logic [3:0] k);
      logic [3:0] r;
      case (k)
         4'd0:    r = M_X;
         4'd1:    r = M_Y;
         4'd2:    r = M_Z;
         4'd3:    r = M_XX;
         4'd4:    r = M_XY;
         4'd5:    r = M_XZ;
         4'd6:    r = M_YY;
         4'd7:    r = M_YZ;
         default: r = M_ZZ;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic [WIDE-1:0] q, input logic neg);
      logic [WIDE-1:0] lim;
      logic [31:0]     r;
      lim = WIDE'(1) << 31;
      if (neg) begin
         r = (q > lim) ? 32'h8000_0000 : (32'd0 - q[31:0]);
      end else begin
         r = (q >= lim) ? 32'h7FFF_FFFF : q[31:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] sat64(input logic [WIDE-1:0] q, input logic neg);
      logic [WIDE-1:0] lim;
      logic [63:0]     r;
      lim = WIDE'(1) << 63;
      if (neg) begin
         r = (q > lim) ? 64'h8000_0000_0000_0000 : (64'd0 - q[63:0]);
      end else begin
         r = (q >= lim) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/weighted_least_squares_plane_fit_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_least_squares_plane_fit_core
// Weighted least-squares fit of z against x and y from running moment sums,
// solved by Cramer's rule on exact 256-bit integers.
// ----------------------------------------------------------------------------
// Timing: an add beat holds busy while its products pass in turn through the
// single 33x17 multiplier, and one more step folds in the last product. A
// clear beat completes at its accept edge. An estimate runs the term program
// of the selected model on the same multiplier, each wide product as 32
// partial products of 32x16 bits, then, if the determinant is nonzero, four
// restoring divisions. The result strobe follows the last cycle of busy and
// lasts one cycle; results cannot be held off, so the receiver must take them
// as they come.
module weighted_least_squares_plane_fit_core
   import wlsq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [15:0]        req_weight,
   input  logic signed [15:0] req_z_value,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_y_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_coef_a,
   output logic signed [31:0] rsp_coef_b,
   output logic signed [31:0] rsp_coef_c,
   output logic signed [63:0] rsp_residual,
   output logic [31:0]        rsp_weight_total,
   output logic               rsp_solved,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [1:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   state_type state_ff, state_in;
   logic [2:0] model_ff, model_in;
   logic signed [MOM_WIDTH-1:0] mom_ff [MOM_DEPTH];
   logic signed [MOM_WIDTH-1:0] mom_in [MOM_DEPTH];
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [15:0]        w_ff, w_in;
   logic signed [15:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [MUL_A_W-1:0] wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;
   logic [3:0] step_ff, step_in;
   logic signed [PROD_W-1:0] pp_ff, pp_in;
   logic [MUL_CNT_W-1:0] mcnt_ff, mcnt_in;
   logic [4:0] off_ff, off_in;
   logic [ROM_W-1:0] idx_ff, idx_in;
   logic fstep_ff, fstep_in;
   logic signed [WIDE-1:0] t_ff, t_in;
   logic [WIDE-1:0] ma_ff, ma_in, prod_ff, prod_in;
   logic [MOM_WIDTH-1:0] mb_ff, mb_in;
   logic msign_ff, msign_in;
   logic signed [WIDE-1:0] det_ff, det_in, na_ff, na_in, nb_ff, nb_in;
   logic signed [WIDE-1:0] nc_ff, nc_in, e_ff, e_in;
   div_type dsel_ff, dsel_in;
   logic [WIDE-1:0] an_ff, an_in, ad_ff, ad_in;
   logic qneg_ff, qneg_in;
   logic [WIDE-1:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic signed [31:0] ca_ff, ca_in, cb_ff, cb_in, cc_ff, cc_in;
   logic signed [63:0] res_ff, res_in;
   logic [31:0] wt_ff, wt_in;
   logic solved_ff, solved_in;

   term_type tm;
   logic [3:0] mom_rd_idx;
   logic signed [MOM_WIDTH-1:0] mom_rd;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [WIDE-1:0] src_wide, addend, div_n, div_d;
   logic [WIDE-1:0] rsh;
   logic rem_ge;
   logic accept, cfg_wr, model_ok, can_add;

   assign tm       = term_rom(idx_ff);
   assign accept   = start && (state_ff == ST_IDLE);
   assign cfg_wr   = psel && penable && pwrite;
   assign model_ok = (model_ff <= MODEL_MAX);
   assign can_add  = (cnt_ff < CNT_WIDTH'(MAX_SAMPLES));

   // read port on the moment sums for the sample, term load and multiply setup states
   always_comb begin
      unique case (state_ff)
         ST_SMP:       mom_rd_idx = smp_dst(step_ff - 4'd1);
         ST_TERM_LOAD: mom_rd_idx = tm.f1;
         ST_MUL_SETUP: mom_rd_idx = fstep_ff ? tm.f3 : tm.f2;
         default:      mom_rd_idx = M_W;
      endcase
   end
   assign mom_rd = (mom_rd_idx < 4'(MOM_DEPTH)) ? mom_ff[mom_rd_idx] : '0;

   always_comb begin
      case (tm.f1)
         S_DET:   src_wide = det_ff;
         S_NA:    src_wide = na_ff;
         S_NB:    src_wide = nb_ff;
         S_NC:    src_wide = nc_ff;
         default: src_wide = {{(WIDE-MOM_WIDTH){mom_rd[MOM_WIDTH-1]}}, mom_rd};
      endcase
   end

   // the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MUL_RUN) begin
         mul_a = {1'b0, ma_ff[{mcnt_ff[4:2], 5'b00000} +: 32]};
         mul_b = {1'b0, mb_ff[{mcnt_ff[1:0], 4'b0000} +: 16]};
      end else begin
         case (step_ff)
            4'd0: begin mul_a = {17'd0, w_ff}; mul_b = MUL_B_W'(x_ff); end
            4'd1: begin mul_a = {17'd0, w_ff}; mul_b = MUL_B_W'(y_ff); end
            4'd2: begin mul_a = {17'd0, w_ff}; mul_b = MUL_B_W'(z_ff); end
            4'd3: begin mul_a = wx_ff;         mul_b = MUL_B_W'(x_ff); end
            4'd4: begin mul_a = wx_ff;         mul_b = MUL_B_W'(y_ff); end
            4'd5: begin mul_a = wx_ff;         mul_b = MUL_B_W'(z_ff); end
            4'd6: begin mul_a = wy_ff;         mul_b = MUL_B_W'(y_ff); end
            4'd7: begin mul_a = wy_ff;         mul_b = MUL_B_W'(z_ff); end
            default: begin mul_a = wz_ff;      mul_b = MUL_B_W'(z_ff); end
         endcase
      end
   end
   assign mul_p = mul_a * mul_b;

   assign addend = tm.dbl ? (t_ff <<< 1) : t_ff;

   always_comb begin
      case (dsel_ff)
         DIV_A:   begin div_n = na_ff <<< COEF_FRAC_BITS; div_d = det_ff; end
         DIV_B:   begin div_n = nb_ff <<< COEF_FRAC_BITS; div_d = det_ff; end
         DIV_C:   begin
            div_n = nc_ff <<< COEF_FRAC_BITS;
            div_d = det_ff <<< C_EXTRA_SHIFT;
         end
         default: begin div_n = e_ff; div_d = det_ff; end
      endcase
   end

   assign rsh    = {rem_ff[WIDE-2:0], num_ff[WIDE-1]};
   assign rem_ge = (rsh >= den_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_ADD:  state_in = can_add ? ST_SMP : ST_IDLE;
                  OP_EST:  state_in = model_ok ? ST_TERM_LOAD : ST_DONE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SMP:       if (step_ff == SMP_LAST) state_in = ST_IDLE;
         ST_TERM_LOAD: state_in = (tm.nf == 2'd1) ? ST_TERM_ACC : ST_MUL_SETUP;
         ST_MUL_SETUP: state_in = ST_MUL_RUN;
         ST_MUL_RUN:   if (mcnt_ff == MUL_CNT_W'(MUL_STEPS)) state_in = ST_MUL_FIX;
         ST_MUL_FIX:   state_in = (tm.nf == 2'd3 && !fstep_ff) ? ST_MUL_SETUP : ST_TERM_ACC;
         ST_TERM_ACC:  state_in = (tm.last && idx_ff >= E_START) ? ST_DIV_SETUP : ST_TERM_LOAD;
         ST_DIV_SETUP: state_in = (det_ff == '0) ? ST_DONE : ST_DIV_PREP;
         ST_DIV_PREP:  state_in = ST_DIV_RUN;
         ST_DIV_RUN:   if (dcnt_ff == DIV_CNT_W'(WIDE - 1)) state_in = ST_DIV_FIX;
         ST_DIV_FIX:   state_in = (dsel_ff == DIV_R) ? ST_DONE : ST_DIV_SETUP;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      model_in     = model_ff;
      mom_in       = mom_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      w_in = w_ff;  x_in = x_ff;  y_in = y_ff;  z_in = z_ff;
      wx_in = wx_ff;  wy_in = wy_ff;  wz_in = wz_ff;
      step_in  = step_ff;
      pp_in    = mul_p;
      mcnt_in  = mcnt_ff;
      off_in   = off_ff;
      idx_in   = idx_ff;
      fstep_in = fstep_ff;
      t_in     = t_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      msign_in = msign_ff;
      prod_in  = prod_ff;
      det_in = det_ff;  na_in = na_ff;  nb_in = nb_ff;  nc_in = nc_ff;  e_in = e_ff;
      dsel_in  = dsel_ff;
      an_in    = an_ff;
      ad_in    = ad_ff;
      qneg_in  = qneg_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      ca_in = ca_ff;  cb_in = cb_ff;  cc_in = cc_ff;  res_in = res_ff;
      wt_in     = wt_ff;
      solved_in = solved_ff;

      if (cfg_wr) model_in = pwdata[2:0];

      unique case (state_ff)
         ST_IDLE: begin
            w_in    = req_weight;
            x_in    = req_x_value;
            y_in    = req_y_value;
            z_in    = req_z_value;
            step_in = '0;
            if (accept) begin
               case (req_opcode)
                  OP_ADD: begin
                     if (can_add) begin
                        mom_in[M_W] = mom_ff[M_W] + MOM_WIDTH'(req_weight);
                        cnt_in      = cnt_ff + 1'b1;
                     end
                  end
                  OP_EST: begin
                     idx_in = model_start(model_ff);
                     det_in = '0;  na_in = '0;  nb_in = '0;  nc_in = '0;  e_in = '0;
                     ca_in = '0;  cb_in = '0;  cc_in = '0;  res_in = '0;
                     solved_in = 1'b0;
                  end
                  OP_CLR: begin
                     for (int i = 0; i < MOM_DEPTH; i++) mom_in[i] = '0;
                     cnt_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SMP: begin
            step_in = step_ff + 4'd1;
            // fold the product issued last cycle
            if (step_ff != 4'd0) begin
               mom_in[mom_rd_idx] = mom_rd + {{(MOM_WIDTH-PROD_W){pp_ff[PROD_W-1]}}, pp_ff};
            end
            if (step_ff == 4'd1) wx_in = pp_ff[MUL_A_W-1:0];
            if (step_ff == 4'd2) wy_in = pp_ff[MUL_A_W-1:0];
            if (step_ff == 4'd3) wz_in = pp_ff[MUL_A_W-1:0];
         end
         ST_TERM_LOAD: begin
            t_in     = src_wide;
            fstep_in = 1'b0;
         end
         ST_MUL_SETUP: begin
            ma_in    = t_ff[WIDE-1] ? WIDE'(-t_ff) : WIDE'(t_ff);
            mb_in    = mom_rd[MOM_WIDTH-1] ? MOM_WIDTH'(-mom_rd) : MOM_WIDTH'(mom_rd);
            msign_in = t_ff[WIDE-1] ^ mom_rd[MOM_WIDTH-1];
            prod_in  = '0;
            mcnt_in  = '0;
         end
         ST_MUL_RUN: begin
            mcnt_in = mcnt_ff + 1'b1;
            off_in  = {1'b0, mcnt_ff[4:2], 1'b0} + {3'b000, mcnt_ff[1:0]};
            if (mcnt_ff != '0) begin
               prod_in = prod_ff + (WIDE'(pp_ff[47:0]) << {off_ff, 4'b0000});
            end
         end
         ST_MUL_FIX: begin
            t_in = msign_ff ? -signed'(prod_ff) : signed'(prod_ff);
            if (tm.nf == 2'd3 && !fstep_ff) fstep_in = 1'b1;
         end
         ST_TERM_ACC: begin
            case (tm.dst)
               DST_DET: det_in = tm.neg ? det_ff - addend : det_ff + addend;
               DST_NA:  na_in  = tm.neg ? na_ff - addend  : na_ff + addend;
               DST_NB:  nb_in  = tm.neg ? nb_ff - addend  : nb_ff + addend;
               DST_NC:  nc_in  = tm.neg ? nc_ff - addend  : nc_ff + addend;
               default: e_in   = tm.neg ? e_ff - addend   : e_ff + addend;
            endcase
            if (tm.last && idx_ff < E_START) begin
               idx_in = E_START;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
            dsel_in = DIV_A;
         end
         ST_DIV_SETUP: begin
            an_in   = div_n[WIDE-1] ? WIDE'(-div_n) : WIDE'(div_n);
            ad_in   = div_d[WIDE-1] ? WIDE'(-div_d) : WIDE'(div_d);
            qneg_in = div_n[WIDE-1] ^ div_d[WIDE-1];
         end
         ST_DIV_PREP: begin
            // round half away: (2|n| + |d|) / 2|d|
            num_in  = (an_ff << 1) + ad_ff;
            den_in  = ad_ff << 1;
            rem_in  = '0;
            dcnt_in = '0;
         end
         ST_DIV_RUN: begin
            rem_in  = rem_ge ? rsh - den_ff : rsh;
            num_in  = {num_ff[WIDE-2:0], rem_ge};
            dcnt_in = dcnt_ff + 1'b1;
         end
         ST_DIV_FIX: begin
            case (dsel_ff)
               DIV_A:   ca_in  = signed'(sat32(num_ff, qneg_ff));
               DIV_B:   cb_in  = signed'(sat32(num_ff, qneg_ff));
               DIV_C:   cc_in  = signed'(sat32(num_ff, qneg_ff));
               default: begin
                  res_in    = signed'(sat64(num_ff, qneg_ff));
                  solved_in = 1'b1;
               end
            endcase
            dsel_in = div_type'(dsel_ff + 2'd1);
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            wt_in        = mom_ff[M_W][31:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         model_ff     <= MODEL_RST;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MOM_DEPTH; i++) mom_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         model_ff     <= model_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         mom_ff       <= mom_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;  x_ff <= x_in;  y_ff <= y_in;  z_ff <= z_in;
      wx_ff <= wx_in;  wy_ff <= wy_in;  wz_ff <= wz_in;
      step_ff  <= step_in;
      pp_ff    <= pp_in;
      mcnt_ff  <= mcnt_in;
      off_ff   <= off_in;
      idx_ff   <= idx_in;
      fstep_ff <= fstep_in;
      t_ff     <= t_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      msign_ff <= msign_in;
      prod_ff  <= prod_in;
      det_ff <= det_in;  na_ff <= na_in;  nb_ff <= nb_in;  nc_ff <= nc_in;  e_ff <= e_in;
      dsel_ff  <= dsel_in;
      an_ff    <= an_in;
      ad_ff    <= ad_in;
      qneg_ff  <= qneg_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      dcnt_ff  <= dcnt_in;
      ca_ff <= ca_in;  cb_ff <= cb_in;  cc_ff <= cc_in;  res_ff <= res_in;
      wt_ff     <= wt_in;
      solved_ff <= solved_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coef_a       = ca_ff;
   assign rsp_coef_b       = cb_ff;
   assign rsp_coef_c       = cc_ff;
   assign rsp_residual     = res_ff;
   assign rsp_weight_total = wt_ff;
   assign rsp_solved       = solved_ff;
   assign prdata           = (paddr == 2'd0) ? {29'd0, model_ff} : 32'd0;
   assign pready           = 1'b1;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_DONE) && !busy)
      else $error("result strobe without a finished estimate");

   a_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_WIDTH'(MAX_SAMPLES))
      else $error("sample count beyond limit");

   a_unsolved_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_solved) |-> (rsp_coef_a == '0) && (rsp_residual == '0))
      else $error("unsolved result carries coefficients");

endmodule
`default_nettype wire

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Weighted plane fit core regression
// Drives add, estimate and clear beats together with model register writes,
// and predicts every fit on exact wide integers. Each strobed result is
// compared field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench
   import wlsq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [383:0] wide_t;

   typedef struct packed {
      logic signed [31:0] coef_a;
      logic signed [31:0] coef_b;
      logic signed [31:0] coef_c;
      logic signed [63:0] residual;
      logic [31:0]        weight_total;
      logic               solved;
   } fit_t;

   class fit_scoreboard;
      longint      sums[10];
      int unsigned n_samples;
      logic [2:0]  model;
      fit_t        pending_fits[$];
      int          errors;

      function new();
         foreach (sums[i]) sums[i] = 0;
         n_samples = 0;
         model     = MODEL_RST;
         errors    = 0;
      endfunction

      // round to nearest, ties away from zero, then saturate to a signed field
      function logic [63:0] round_sat(wide_t n, wide_t d, int bits);
         logic        neg;
         logic [383:0] an, ad, q, lim;
         neg = n[383] ^ d[383];
         an  = n[383] ? -n : n;
         ad  = d[383] ? -d : d;
         q   = ((an << 1) + ad) / (ad << 1);
         lim = 384'd1 << (bits - 1);
         if (neg) return (q > lim) ? lim[63:0] : (64'd0 - q[63:0]);
         return (q >= lim) ? (lim[63:0] - 64'd1) : q[63:0];
      endfunction

      function fit_t solve_fit();
         fit_t  r;
         wide_t m[10];
         wide_t det, na, nb, nc, e;
         logic [63:0] v;
         r = '0;
         r.weight_total = sums[M_W][31:0];
         foreach (m[i]) m[i] = sums[i];
         det = 0; na = 0; nb = 0; nc = 0;
         case (model)
            3'd0: begin
               det = m[M_W]; nc = m[M_Z];
            end
            3'd1: begin
               det = m[M_XX]; na = m[M_XZ];
            end
            3'd2: begin
               det = m[M_W] * m[M_XX] - m[M_X] * m[M_X];
               na  = m[M_W] * m[M_XZ] - m[M_X] * m[M_Z];
               nc  = m[M_Z] * m[M_XX] - m[M_X] * m[M_XZ];
            end
            3'd3: begin
               det = m[M_XX] * m[M_YY] - m[M_XY] * m[M_XY];
               na  = m[M_YY] * m[M_XZ] - m[M_XY] * m[M_YZ];
               nb  = m[M_XX] * m[M_YZ] - m[M_XY] * m[M_XZ];
            end
            3'd4: begin
               det = m[M_YY] * m[M_XX] * m[M_W] - m[M_YY] * m[M_X] * m[M_X]
                   - m[M_XX] * m[M_Y] * m[M_Y] - m[M_XY] * m[M_XY] * m[M_W]
                   + 2 * m[M_X] * m[M_XY] * m[M_Y];
               na  = m[M_YY] * m[M_XZ] * m[M_W] - m[M_YY] * m[M_X] * m[M_Z]
                   - m[M_XZ] * m[M_Y] * m[M_Y] + m[M_X] * m[M_Y] * m[M_YZ]
                   + m[M_Y] * m[M_XY] * m[M_Z] - m[M_XY] * m[M_YZ] * m[M_W];
               nb  = m[M_YZ] * m[M_XX] * m[M_W] - m[M_YZ] * m[M_X] * m[M_X]
                   - m[M_XY] * m[M_XZ] * m[M_W] + m[M_XY] * m[M_X] * m[M_Z]
                   - m[M_Y] * m[M_XX] * m[M_Z] + m[M_Y] * m[M_X] * m[M_XZ];
               nc  = m[M_YY] * m[M_XX] * m[M_Z] + m[M_Y] * m[M_XY] * m[M_XZ]
                   - m[M_XX] * m[M_Y] * m[M_YZ] - m[M_YY] * m[M_X] * m[M_XZ]
                   - m[M_XY] * m[M_XY] * m[M_Z] + m[M_X] * m[M_XY] * m[M_YZ];
            end
            default: return r;
         endcase
         if (det == 0) return r;
         v = round_sat(na <<< COEF_FRAC_BITS, det, 32);
         r.coef_a = v[31:0];
         v = round_sat(nb <<< COEF_FRAC_BITS, det, 32);
         r.coef_b = v[31:0];
         v = round_sat(nc <<< COEF_FRAC_BITS, det <<< C_EXTRA_SHIFT, 32);
         r.coef_c = v[31:0];
         e = m[M_ZZ] * det - na * m[M_XZ] - nb * m[M_YZ] - nc * m[M_Z];
         r.residual = round_sat(e, det, 64);
         r.solved   = 1'b1;
         return r;
      endfunction

      function void note_beat(op_type op, logic [15:0] w, logic signed [15:0] z,
                              logic signed [15:0] x, logic signed [15:0] y);
         longint lw, lz, lx, ly;
         lw = w; lz = z; lx = x; ly = y;
         case (op)
            OP_ADD: begin
               if (n_samples < MAX_SAMPLES) begin
                  n_samples++;
                  sums[M_W]  += lw;
                  sums[M_X]  += lw * lx;
                  sums[M_Y]  += lw * ly;
                  sums[M_Z]  += lw * lz;
                  sums[M_XX] += lw * lx * lx;
                  sums[M_XY] += lw * lx * ly;
                  sums[M_XZ] += lw * lx * lz;
                  sums[M_YY] += lw * ly * ly;
                  sums[M_YZ] += lw * ly * lz;
                  sums[M_ZZ] += lw * lz * lz;
               end
            end
            OP_EST: pending_fits.push_back(solve_fit());
            OP_CLR: begin
               foreach (sums[i]) sums[i] = 0;
               n_samples = 0;
            end
            default: ;
         endcase
      endfunction

      function void check_beat(fit_t got);
         fit_t exp_fit;
         if (pending_fits.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            errors++;
            return;
         end
         exp_fit = pending_fits.pop_front();
         if (got.coef_a !== exp_fit.coef_a) begin
            $display("%0t: coef_a exp %h got %h", $time, exp_fit.coef_a, got.coef_a);
            errors++;
         end
         if (got.coef_b !== exp_fit.coef_b) begin
            $display("%0t: coef_b exp %h got %h", $time, exp_fit.coef_b, got.coef_b);
            errors++;
         end
         if (got.coef_c !== exp_fit.coef_c) begin
            $display("%0t: coef_c exp %h got %h", $time, exp_fit.coef_c, got.coef_c);
            errors++;
         end
         if (got.residual !== exp_fit.residual) begin
            $display("%0t: residual exp %h got %h", $time, exp_fit.residual, got.residual);
            errors++;
         end
         if (got.weight_total !== exp_fit.weight_total) begin
            $display("%0t: weight_total exp %h got %h", $time, exp_fit.weight_total,
                     got.weight_total);
            errors++;
         end
         if (got.solved !== exp_fit.solved) begin
            $display("%0t: solved exp %b got %b", $time, exp_fit.solved, got.solved);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = OP_NOP;
   logic [15:0]        req_weight = '0;
   logic signed [15:0] req_z_value = '0;
   logic signed [15:0] req_x_value = '0;
   logic signed [15:0] req_y_value = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_coef_a, rsp_coef_b, rsp_coef_c;
   logic signed [63:0] rsp_residual;
   logic [31:0]        rsp_weight_total;
   logic               rsp_solved;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [1:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   fit_scoreboard fits = new();
   int            burst_left = 4;
   int            n_items = 0;
   int            n_fits = 0;

   weighted_least_squares_plane_fit_core i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         fits.check_beat({rsp_coef_a, rsp_coef_b, rsp_coef_c, rsp_residual,
                          rsp_weight_total, rsp_solved});
         n_fits++;
      end
   end

   // hold start high across a burst; drop it only for a gap
   task automatic send_beat(op_type op, logic [15:0] w, logic [15:0] z, logic [15:0] x,
                            logic [15:0] y);
      start       <= 1'b1;
      req_opcode  <= op;
      req_weight  <= w;
      req_z_value <= z;
      req_x_value <= x;
      req_y_value <= y;
      @(posedge clock);
      while (busy) @(posedge clock);
      fits.note_beat(op, w, z, x, y);
      n_items++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (fits.pending_fits.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_model(logic [2:0] m);
      drain();
      psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {29'd0, m};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      fits.model = m;
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {29'd0, m}) begin
         $display("%0t: model readback exp %h got %h", $time, {29'd0, m}, prdata);
         fits.errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_value(int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 1023)) - 16'd512;
         default: return ($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   // one phase: optional clear, a run of samples, then an estimate
   task automatic fit_phase();
      int          n, style, shape, i;
      logic [15:0] w, z, x, y;
      style = $urandom_range(0, 3);
      shape = $urandom_range(0, 5);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) send_beat(OP_CLR, 16'($urandom), 16'($urandom),
                                              16'($urandom), 16'($urandom));
      for (i = 0; i < n; i++) begin
         w = ($urandom_range(0, 9) == 0) ? 16'd0 :
             ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
         x = pick_value(style);
         y = pick_value(style);
         case (shape)
            0: y = x;            // collinear: singular for two variables
            1: x = 16'h0100;     // constant x: singular for ax+c
            default: ;
         endcase
         z = (shape == 2) ? 16'(3 * x - 2 * y + 256) : pick_value(style);
         if ($urandom_range(0, 19) == 0) send_beat(OP_NOP, w, z, x, y);
         send_beat(OP_ADD, w, z, x, y);
      end
      send_beat(OP_EST, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      int i;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty sums, reset model
      send_beat(OP_EST, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_beat(OP_ADD, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF);
      send_beat(OP_ADD, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
      send_beat(OP_ADD, 16'h8000, 16'h0100, 16'h0200, 16'hFF00);
      send_beat(OP_ADD, 16'h0001, 16'hFFFF, 16'h0001, 16'h0003);
      send_beat(OP_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(OP_EST, 16'h0, 16'h0, 16'h0, 16'h0);
      for (i = 0; i < 8; i++) begin
         write_model(3'(i));
         send_beat(OP_EST, 16'h0, 16'h0, 16'h0, 16'h0);
      end
      write_model(3'd4);
      send_beat(OP_CLR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_beat(OP_EST, 16'h0, 16'h0, 16'h0, 16'h0);

      n_items = 0;
      while (n_items < 900 || n_fits < 60) begin
         if ($urandom_range(0, 2) == 0)
            write_model(($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4)));
         fit_phase();
      end

      drain();
      if (fits.errors == 0)
         $display("weighted_least_squares_plane_fit_core regression: pass");
      else
         $display("weighted_least_squares_plane_fit_core regression: fail");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("weighted_least_squares_plane_fit_core regression: fail");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/wlsq_pkg.sv
hw/rtl/weighted_least_squares_plane_fit_core.sv
tb/testbench.sv
